[rtl/dwqpl_pkg.sv]
// Shared types and constants for the dual-wheel quadrature position loop.
// Holds the register map, the pipeline enable bundle and the Gray-code step decoder.
// No dependencies.
`default_nettype none

package dwqpl_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 18;
	localparam int ERR_W       = 32;
	localparam int DRIVE_W     = 18;
	localparam int GAIN_W      = 20;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PROP_GAIN   = 3'd0,
		CFG_DERIV_GAIN  = 3'd1,
		CFG_DRIVE_BIAS  = 3'd2,
		CFG_BASE_SPEED  = 3'd3,
		CFG_EDGE_WEIGHT = 3'd4,
		CFG_LEFT_INVERT = 3'd5,
		CFG_LOOP_ENABLE = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_FWD  = 2'd1,
		STEP_REV  = 2'd2
	} step_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

	function automatic step_t gray_step(input logic [1:0] prev, input logic [1:0] cur);
		step_t s;
		unique case ({prev, cur}) inside
			4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_FWD;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_REV;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

[rtl/dwqpl_wheel.sv]
// Quadrature decoder and saturating position counter for one wheel.
// Depends on dwqpl_pkg for the Gray-code step decoder.
`default_nettype none

module dwqpl_wheel #(
	parameter int POS_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        sample_en,
	input  wire logic [1:0]                  phase,
	input  wire logic [7:0]                  edge_weight,
	output logic signed [POS_WIDTH-1:0]      count
);
	import dwqpl_pkg::*;

	logic signed [POS_WIDTH-1:0] count_q;
	logic [1:0]                  prev_q;
	step_t                       step;
	logic signed [POS_WIDTH:0]   delta;
	logic signed [POS_WIDTH:0]   sum;
	logic signed [POS_WIDTH-1:0] count_next;

	assign step = gray_step(prev_q, phase);

	always_comb begin
		case (step)
			STEP_FWD: delta = (POS_WIDTH+1)'($signed({1'b0, edge_weight}));
			STEP_REV: delta = -(POS_WIDTH+1)'($signed({1'b0, edge_weight}));
			default:  delta = '0;
		endcase
		sum = (POS_WIDTH+1)'(count_q) + delta;
		if (sum[POS_WIDTH] != sum[POS_WIDTH-1]) begin
			count_next = sum[POS_WIDTH] ? {1'b1, {(POS_WIDTH-1){1'b0}}}
			                            : {1'b0, {(POS_WIDTH-1){1'b1}}};
		end else begin
			count_next = sum[POS_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
		end else if (sample_en) begin
			count_q <= count_next;
			prev_q  <= phase;
		end
	end

	assign count = count_q;

endmodule

`default_nettype wire

[rtl/dwqpl_drive.sv]
// Drive pipeline for one wheel: position error, gain and bias, clamp, duty scaling.
// Depends on dwqpl_pkg for widths and the stage enable bundle.
`default_nettype none

module dwqpl_drive #(
	parameter int POS_WIDTH = 32,
	parameter int DUTY_MAX  = 254
) (
	input  wire logic                                clk,
	input  wire dwqpl_pkg::pipe_ctl_t                ctl,
	input  wire logic signed [POS_WIDTH-1:0]         setpoint,
	input  wire logic signed [POS_WIDTH-1:0]         count,
	input  wire logic [15:0]                         prop_gain,
	input  wire logic [15:0]                         deriv_gain,
	input  wire logic signed [dwqpl_pkg::DRIVE_W-1:0] drive_bias,
	output logic [7:0]                               duty,
	output logic                                     drive_pos,
	output logic signed [dwqpl_pkg::ERR_W-1:0]       pos_error
);
	import dwqpl_pkg::*;

	localparam int DIFF_W = (POS_WIDTH + 1 > ERR_W + 1) ? POS_WIDTH + 1 : ERR_W + 1;
	localparam int SUM_W  = ERR_W + GAIN_W + 2;
	localparam logic signed [SUM_W-1:0] Q_POS = SUM_W'(65536);
	localparam logic signed [SUM_W-1:0] Q_NEG = -Q_POS;
	localparam logic [15:0] DUTY_K = 16'(DUTY_MAX);

	logic signed [POS_WIDTH-1:0] sp_s1;
	logic signed [POS_WIDTH-1:0] cnt_s1;
	logic signed [ERR_W-1:0]     err_s2;
	logic signed [ERR_W-1:0]     err_s3;
	logic signed [DRIVE_W-1:0]   drive_s3;
	logic signed [ERR_W-1:0]     err_s4;
	logic [7:0]                  duty_s4;
	logic                        pos_s4;

	logic signed [DIFF_W-1:0]    diff;
	logic signed [ERR_W-1:0]     err_sat;
	logic [GAIN_W-1:0]           gain;
	logic signed [GAIN_W:0]      gain_s;
	logic signed [SUM_W-2:0]     prod;
	logic signed [SUM_W-1:0]     sum;
	logic signed [DRIVE_W-1:0]   drive_clamped;
	logic [16:0]                 mag;
	logic [32:0]                 scaled;

	always_comb begin
		diff = DIFF_W'(sp_s1) - DIFF_W'(cnt_s1);
		if (diff[DIFF_W-1:ERR_W-1] == '0 || diff[DIFF_W-1:ERR_W-1] == '1) begin
			err_sat = diff[ERR_W-1:0];
		end else begin
			err_sat = diff[DIFF_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
		end
	end

	always_comb begin
		gain   = GAIN_W'(prop_gain) + (GAIN_W'(deriv_gain) << 3) + (GAIN_W'(deriv_gain) << 1);
		gain_s = $signed({1'b0, gain});
		prod   = err_s2 * gain_s;
		sum    = SUM_W'(prod) + SUM_W'(drive_bias);
		if (sum > Q_POS) begin
			drive_clamped = DRIVE_W'(Q_POS);
		end else if (sum < Q_NEG) begin
			drive_clamped = DRIVE_W'(Q_NEG);
		end else begin
			drive_clamped = DRIVE_W'(sum);
		end
	end

	always_comb begin
		mag    = drive_s3[DRIVE_W-1] ? 17'(-drive_s3) : 17'(drive_s3);
		scaled = 33'(mag) * 33'(DUTY_K);
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			sp_s1  <= setpoint;
			cnt_s1 <= count;
		end
		if (ctl.en_s2) begin
			err_s2 <= err_sat;
		end
		if (ctl.en_s3) begin
			err_s3   <= err_s2;
			drive_s3 <= drive_clamped;
		end
		if (ctl.en_s4) begin
			err_s4  <= err_s3;
			duty_s4 <= scaled[23:16];
			pos_s4  <= !drive_s3[DRIVE_W-1] && (drive_s3 != '0);
		end
	end

	assign duty      = duty_s4;
	assign drive_pos = pos_s4;
	assign pos_error = err_s4;

endmodule

`default_nettype wire

[rtl/dual_wheel_quadrature_position_loop.sv]
// Two-wheel quadrature position loop with proportional drive: top level.
// Depends on dwqpl_pkg, dwqpl_wheel and dwqpl_drive.
//
// Encoder samples and control ticks share one input channel and one can be taken every
// cycle while in_stall is low. A sample updates both wheel counts in the cycle it is taken and gives no result.
// An enabled tick advances both setpoints at once and its result is registered through
// the input capture, error, gain multiply and duty scaling stages before it is presented;
// those stages hold up to four ticks, and in_stall rises only when all of them are full
// and out_stall is high.
`default_nettype none

module dual_wheel_quadrature_position_loop #(
	parameter int POS_WIDTH = 32,
	parameter int DUTY_MAX  = 254
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [dwqpl_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [dwqpl_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   kind,
	input  wire logic                                   left_phase_a,
	input  wire logic                                   left_phase_b,
	input  wire logic                                   right_phase_a,
	input  wire logic                                   right_phase_b,
	input  wire logic signed [10:0]                     steer_error,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [7:0]                                  left_duty,
	output logic                                        left_dir,
	output logic [7:0]                                  right_duty,
	output logic                                        right_dir,
	output logic signed [dwqpl_pkg::ERR_W-1:0]          left_pos_error,
	output logic signed [dwqpl_pkg::ERR_W-1:0]          right_pos_error
);
	import dwqpl_pkg::*;

	logic [15:0]                 prop_gain_q;
	logic [15:0]                 deriv_gain_q;
	logic signed [DRIVE_W-1:0]   drive_bias_q;
	logic [11:0]                 base_speed_q;
	logic [7:0]                  edge_weight_q;
	logic                        left_invert_q;
	logic                        loop_enable_q;

	logic signed [POS_WIDTH-1:0] left_sp_q;
	logic signed [POS_WIDTH-1:0] right_sp_q;
	logic signed [POS_WIDTH-1:0] left_sp_next;
	logic signed [POS_WIDTH-1:0] right_sp_next;
	logic signed [POS_WIDTH-1:0] left_count;
	logic signed [POS_WIDTH-1:0] right_count;

	logic                        v_s1, v_s2, v_s3, v_s4;
	pipe_ctl_t                   ctl;
	logic                        in_beat;
	logic                        sample_en;
	logic                        tick_en;
	logic [1:0]                  left_phase;
	logic [1:0]                  right_phase;
	logic signed [13:0]          adv_left;
	logic signed [13:0]          adv_right;
	logic                        left_pos;
	logic                        right_pos;

	function automatic logic signed [POS_WIDTH-1:0] sp_step(
		input logic signed [POS_WIDTH-1:0] sp,
		input logic signed [13:0]          adv
	);
		logic signed [POS_WIDTH+1:0] s;
		logic signed [POS_WIDTH-1:0] r;
		s = (POS_WIDTH+2)'(sp) + (POS_WIDTH+2)'(adv);
		if (s[POS_WIDTH+1:POS_WIDTH-1] == '0 || s[POS_WIDTH+1:POS_WIDTH-1] == '1) begin
			r = s[POS_WIDTH-1:0];
		end else begin
			r = s[POS_WIDTH+1] ? {1'b1, {(POS_WIDTH-1){1'b0}}} : {1'b0, {(POS_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

	always_comb begin
		ctl.en_s4 = !v_s4 || !out_stall;
		ctl.en_s3 = !v_s3 || ctl.en_s4;
		ctl.en_s2 = !v_s2 || ctl.en_s3;
		ctl.en_s1 = !v_s1 || ctl.en_s2;
	end

	assign in_stall  = !ctl.en_s1;
	assign in_beat   = in_valid && !in_stall;
	assign sample_en = in_beat && (kind == KIND_SAMPLE);
	assign tick_en   = in_beat && (kind == KIND_TICK) && loop_enable_q;

	assign left_phase  = {left_phase_b, left_phase_a} ^ {2{left_invert_q}};
	assign right_phase = {right_phase_b, right_phase_a};

	assign adv_left      = 14'($signed({1'b0, base_speed_q})) - 14'(steer_error);
	assign adv_right     = 14'($signed({1'b0, base_speed_q})) + 14'(steer_error);
	assign left_sp_next  = sp_step(left_sp_q, adv_left);
	assign right_sp_next = sp_step(right_sp_q, adv_right);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= 16'd66;
			deriv_gain_q  <= 16'd0;
			drive_bias_q  <= 18'sd32768;
			base_speed_q  <= 12'd300;
			edge_weight_q <= 8'd100;
			left_invert_q <= 1'b1;
			loop_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PROP_GAIN:   prop_gain_q   <= cfg_data[15:0];
				CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data[15:0];
				CFG_DRIVE_BIAS:  drive_bias_q  <= $signed(cfg_data);
				CFG_BASE_SPEED:  base_speed_q  <= cfg_data[11:0];
				CFG_EDGE_WEIGHT: edge_weight_q <= cfg_data[7:0];
				CFG_LEFT_INVERT: left_invert_q <= cfg_data[0];
				CFG_LOOP_ENABLE: loop_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_sp_q  <= '0;
			right_sp_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
		end else begin
			if (tick_en) begin
				left_sp_q  <= left_sp_next;
				right_sp_q <= right_sp_next;
			end
			if (ctl.en_s1) v_s1 <= tick_en;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
		end
	end

	dwqpl_wheel #(.POS_WIDTH(POS_WIDTH)) u_left_wheel (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_en   (sample_en),
		.phase       (left_phase),
		.edge_weight (edge_weight_q),
		.count       (left_count)
	);

	dwqpl_wheel #(.POS_WIDTH(POS_WIDTH)) u_right_wheel (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_en   (sample_en),
		.phase       (right_phase),
		.edge_weight (edge_weight_q),
		.count       (right_count)
	);

	dwqpl_drive #(.POS_WIDTH(POS_WIDTH), .DUTY_MAX(DUTY_MAX)) u_left_drive (
		.clk        (clk),
		.ctl        (ctl),
		.setpoint   (left_sp_next),
		.count      (left_count),
		.prop_gain  (prop_gain_q),
		.deriv_gain (deriv_gain_q),
		.drive_bias (drive_bias_q),
		.duty       (left_duty),
		.drive_pos  (left_pos),
		.pos_error  (left_pos_error)
	);

	dwqpl_drive #(.POS_WIDTH(POS_WIDTH), .DUTY_MAX(DUTY_MAX)) u_right_drive (
		.clk        (clk),
		.ctl        (ctl),
		.setpoint   (right_sp_next),
		.count      (right_count),
		.prop_gain  (prop_gain_q),
		.deriv_gain (deriv_gain_q),
		.drive_bias (drive_bias_q),
		.duty       (right_duty),
		.drive_pos  (right_pos),
		.pos_error  (right_pos_error)
	);

	assign out_valid = v_s4;
	assign left_dir  = left_pos;
	assign right_dir = !right_pos;

endmodule

`default_nettype wire

[dv/wheel_command_checker.sv]
// Checker for the dual-wheel quadrature position loop: follows register writes, mirrors
// wheel counts on samples and setpoints on enabled ticks and compares each result beat.
// Depends on dwqpl_pkg.
module wheel_command_checker #(
	parameter int POS_WIDTH = 32,
	parameter int DUTY_MAX  = 254
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [dwqpl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dwqpl_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                kind,
	input  logic                                left_phase_a,
	input  logic                                left_phase_b,
	input  logic                                right_phase_a,
	input  logic                                right_phase_b,
	input  logic signed [10:0]                  steer_error,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [7:0]                          left_duty,
	input  logic                                left_dir,
	input  logic [7:0]                          right_duty,
	input  logic                                right_dir,
	input  logic signed [dwqpl_pkg::ERR_W-1:0]  left_pos_error,
	input  logic signed [dwqpl_pkg::ERR_W-1:0]  right_pos_error,
	output int                                  mismatches,
	output int                                  outstanding,
	output int                                  results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import dwqpl_pkg::*;

	typedef struct packed {
		logic [7:0]               left_duty;
		logic                     left_dir;
		logic [7:0]               right_duty;
		logic                     right_dir;
		logic signed [ERR_W-1:0]  left_err;
		logic signed [ERR_W-1:0]  right_err;
	} wheel_cmd_t;

	localparam longint POS_HI     = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
	localparam longint POS_LO     = -POS_HI - 64'sd1;
	localparam longint ERR_HI     = 64'sd2147483647;
	localparam longint ERR_LO     = -64'sd2147483648;
	localparam longint FULL_SCALE = 64'sd65536;

	logic [15:0]         gain_prop;
	logic [15:0]         gain_deriv;
	logic signed [17:0]  bias;
	logic [11:0]         speed;
	logic [7:0]          weight;
	logic                inv_left;
	logic                loop_on;

	longint              count_l, count_r, target_l, target_r, err_l, err_r;
	logic [1:0]          last_l, last_r, cur_l, cur_r;
	logic [7:0]          duty_tmp;
	logic                fwd;
	wheel_cmd_t          cmd, head;
	wheel_cmd_t          pending_cmds[$];

	function automatic longint sat(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [1:0] gray_succ(input logic [1:0] p);
		case (p)
			2'd0: return 2'd1;
			2'd1: return 2'd3;
			2'd3: return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic longint edge_delta(input logic [1:0] prev, input logic [1:0] cur,
			input logic [7:0] w);
		if (cur == gray_succ(prev))
			return longint'(w);
		if (prev == gray_succ(cur))
			return -longint'(w);
		return 0;
	endfunction

	function automatic void drive_level(input longint err, output logic [7:0] duty,
			output logic forward);
		longint g, d, mag;
		g = longint'(gain_prop) + 10 * longint'(gain_deriv);
		d = sat(longint'(bias) + err * g, -FULL_SCALE, FULL_SCALE);
		mag = (d < 0) ? -d : d;
		duty = 8'((mag * DUTY_MAX) >>> 16);
		forward = d > 0;
	endfunction

	task automatic note_mismatch(input string field, input longint want, input longint got);
		$display("%0t checker: %s expected %0d actual %0d", $time, field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop = 16'd66;
			gain_deriv = 16'd0;
			bias = 18'sd32768;
			speed = 12'd300;
			weight = 8'd100;
			inv_left = 1'b1;
			loop_on = 1'b0;
			count_l = 0;
			count_r = 0;
			target_l = 0;
			target_r = 0;
			last_l = 2'd0;
			last_r = 2'd0;
			pending_cmds.delete();
			mismatches = 0;
			outstanding = 0;
			results_checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_cmds.size() == 0) begin
					$display("%0t checker: result beat with no command expected", $time);
					mismatches++;
				end else begin
					head = pending_cmds.pop_front();
					if (left_duty !== head.left_duty)
						note_mismatch("left_duty", head.left_duty, left_duty);
					if (left_dir !== head.left_dir)
						note_mismatch("left_dir", head.left_dir, left_dir);
					if (right_duty !== head.right_duty)
						note_mismatch("right_duty", head.right_duty, right_duty);
					if (right_dir !== head.right_dir)
						note_mismatch("right_dir", head.right_dir, right_dir);
					if (left_pos_error !== head.left_err)
						note_mismatch("left_pos_error", head.left_err, left_pos_error);
					if (right_pos_error !== head.right_err)
						note_mismatch("right_pos_error", head.right_err, right_pos_error);
					results_checked++;
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_PROP_GAIN:   gain_prop = cfg_data[15:0];
					CFG_DERIV_GAIN:  gain_deriv = cfg_data[15:0];
					CFG_DRIVE_BIAS:  bias = cfg_data[17:0];
					CFG_BASE_SPEED:  speed = cfg_data[11:0];
					CFG_EDGE_WEIGHT: weight = cfg_data[7:0];
					CFG_LEFT_INVERT: inv_left = cfg_data[0];
					CFG_LOOP_ENABLE: loop_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (kind == KIND_SAMPLE) begin
					cur_l = {left_phase_b, left_phase_a} ^ {2{inv_left}};
					cur_r = {right_phase_b, right_phase_a};
					count_l = sat(count_l + edge_delta(last_l, cur_l, weight), POS_LO, POS_HI);
					count_r = sat(count_r + edge_delta(last_r, cur_r, weight), POS_LO, POS_HI);
					last_l = cur_l;
					last_r = cur_r;
				end else if (loop_on) begin
					target_l = sat(target_l + longint'(speed) - longint'(steer_error),
						POS_LO, POS_HI);
					target_r = sat(target_r + longint'(speed) + longint'(steer_error),
						POS_LO, POS_HI);
					err_l = sat(target_l - count_l, ERR_LO, ERR_HI);
					err_r = sat(target_r - count_r, ERR_LO, ERR_HI);
					drive_level(err_l, duty_tmp, fwd);
					cmd.left_duty = duty_tmp;
					cmd.left_dir = fwd;
					drive_level(err_r, duty_tmp, fwd);
					cmd.right_duty = duty_tmp;
					cmd.right_dir = !fwd;
					cmd.left_err = err_l[ERR_W-1:0];
					cmd.right_err = err_r[ERR_W-1:0];
					pending_cmds.push_back(cmd);
				end
			end
			outstanding = pending_cmds.size();
		end
	end

endmodule

[dv/testbench.sv]
// Top of the position loop testbench: clock, reset, register programming and beat stimulus.
// Depends on dwqpl_pkg, dual_wheel_quadrature_position_loop and wheel_command_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dwqpl_pkg::*;

	localparam int CLK_PERIOD      = 20;
	localparam int RESET_CYCLES    = 9;
	localparam int RANDOM_PHASES   = 8;
	localparam int BEATS_PER_PHASE = 210;
	localparam int SETTLE_CYCLES   = 8;
	localparam int IDLE_LIMIT      = 5000;
	localparam int TICK_PCT        = 12;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd7;
	localparam logic [7:0] GRAY_ORDER = {2'd2, 2'd3, 2'd1, 2'd0};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     kind = KIND_SAMPLE;
	logic                     left_phase_a = 1'b0;
	logic                     left_phase_b = 1'b0;
	logic                     right_phase_a = 1'b0;
	logic                     right_phase_b = 1'b0;
	logic signed [10:0]       steer_error = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [7:0]               left_duty;
	logic                     left_dir;
	logic [7:0]               right_duty;
	logic                     right_dir;
	logic signed [ERR_W-1:0]  left_pos_error;
	logic signed [ERR_W-1:0]  right_pos_error;

	int   mismatches, outstanding, results_checked;
	int   send_gap_pct = 0;
	int   hold_pct = 0;
	int   beats_sent = 0;
	int   settings_used = 0;
	int   idle_run = 0;
	logic inv_left = 1'b1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	dual_wheel_quadrature_position_loop dut (.*);

	wheel_command_checker checker_i (.*);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < hold_pct);

	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_run <= 0;
		end else if (idle_run >= IDLE_LIMIT) begin
			$display("%0t watchdog: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("tb: failure");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	task automatic send_beat(input logic k, input logic [1:0] lpins, input logic [1:0] rpins,
			input logic signed [10:0] steer);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		left_phase_a <= lpins[0];
		left_phase_b <= lpins[1];
		right_phase_a <= rpins[0];
		right_phase_b <= rpins[1];
		steer_error <= steer;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_sample(input logic [1:0] lpins, input logic [1:0] rpins);
		send_beat(KIND_SAMPLE, lpins, rpins, 11'($urandom));
	endtask

	task automatic send_tick(input logic signed [10:0] steer);
		send_beat(KIND_TICK, 2'($urandom), 2'($urandom), steer);
	endtask

	task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == CFG_LEFT_INVERT)
			inv_left = v[0];
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] p, input logic [15:0] d,
			input logic [17:0] b, input logic [11:0] s, input logic [7:0] w,
			input logic inv, input logic en);
		set_reg(CFG_PROP_GAIN, CFG_DATA_W'(p));
		set_reg(CFG_DERIV_GAIN, CFG_DATA_W'(d));
		set_reg(CFG_DRIVE_BIAS, b);
		set_reg(CFG_BASE_SPEED, CFG_DATA_W'(s));
		set_reg(CFG_EDGE_WEIGHT, CFG_DATA_W'(w));
		set_reg(CFG_LEFT_INVERT, CFG_DATA_W'(inv));
		set_reg(CFG_LOOP_ENABLE, CFG_DATA_W'(en));
		set_reg(CFG_UNMAPPED, 18'($urandom));
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// drop valid, drain expected results, then let the pipeline settle
	task automatic quiesce();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic wander(inout int pos, inout logic rev, output logic [1:0] phase);
		if ($urandom_range(99) < 3)
			rev = ~rev;
		if ($urandom_range(99) < 80)
			pos = rev ? (pos + 3) % 4 : (pos + 1) % 4;
		else
			pos = $urandom_range(3);
		phase = GRAY_ORDER[2*pos +: 2];
	endtask

	initial begin
		int               pos_l, pos_r;
		logic             rev_l, rev_r;
		logic [1:0]       lph, rph;
		logic signed [10:0] steer;

		pos_l = 0;
		pos_r = 0;
		rev_l = 1'b0;
		rev_r = 1'b1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: loop off, left phases inverted
		send_tick(11'sd0);
		send_sample(2'b10, 2'b10);
		send_sample(2'b00, 2'b11);
		send_sample(2'b01, 2'b01);
		send_sample(2'b11, 2'b00);
		send_sample(2'b11, 2'b00);
		send_sample(2'b00, 2'b11);
		send_sample(2'b01, 2'b01);

		quiesce();
		program_regs(16'd2000, 16'd40, 18'd32768, 12'd300, 8'd255, 1'b0, 1'b1);
		send_tick(11'sh400);
		send_tick(11'sh3FF);
		send_tick(11'sd0);
		send_sample(2'b00, 2'b00);
		send_sample(2'b01, 2'b10);
		send_sample(2'b11, 2'b11);
		send_sample(2'b10, 2'b01);
		send_tick(11'sd5);
		send_tick(-11'sd1);

		// zero drive: left direction pin low, right direction pin high
		quiesce();
		program_regs(16'd0, 16'd0, 18'd0, 12'd0, 8'd1, 1'b1, 1'b1);
		send_tick(11'sd0);
		send_tick(11'sd7);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			quiesce();
			case (ph % 4)
				0: begin
					send_gap_pct = 0;
					hold_pct = 0;
				end
				1: begin
					send_gap_pct = 73;
					hold_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					hold_pct = 73;
				end
				default: begin
					send_gap_pct = 35;
					hold_pct = 35;
				end
			endcase
			case (ph)
				0: program_regs('0, '0, 18'h20000, '0, '0, 1'b0, 1'b1);
				1: program_regs(16'hFFFF, 16'hFFFF, 18'h1FFFF, 12'hFFF, 8'hFF, 1'b1, 1'b1);
				2: program_regs(16'($urandom), 16'($urandom), 18'($urandom), 12'($urandom),
					8'($urandom), 1'($urandom), 1'b0);
				3: program_regs(16'($urandom_range(200)), 16'($urandom_range(20)),
					18'(int'($urandom_range(131072)) - 65536), 12'($urandom_range(400)),
					8'($urandom_range(255, 1)), 1'($urandom), 1'b1);
				default: program_regs(16'($urandom), 16'($urandom), 18'($urandom),
					12'($urandom), 8'($urandom), 1'($urandom), 1'b1);
			endcase
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				if ($urandom_range(99) < TICK_PCT) begin
					if ($urandom_range(1) == 0)
						steer = 11'($urandom);
					else
						steer = 11'(int'($urandom_range(16)) - 8);
					send_tick(steer);
				end else begin
					wander(pos_l, rev_l, lph);
					wander(pos_r, rev_r, rph);
					send_sample(lph ^ {2{inv_left}}, rph);
				end
			end
		end

		send_gap_pct = 0;
		hold_pct = 0;
		quiesce();
		$display("tb: drove %0d input beats under %0d register settings, %0d results compared",
			beats_sent, settings_used + 1, results_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
